// ===== hdl/vrvp_pkg.sv =====
// Package for the video register VRAM port: operation codes, register
// indexes and mirroring modes. No dependencies.
package vrvp_pkg;

    localparam int NAMETABLE_BYTES_DEF  = 2048;
    localparam int PATTERN_BYTES_DEF    = 8192;
    localparam int SPRITE_MEM_BYTES     = 256;
    localparam int PALETTE_BYTES        = 32;
    localparam int QUEUE_DEPTH          = 2;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_READ   = 2'd1,
        OP_STATUS = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    localparam logic [2:0] REG_CTRL   = 3'd0;
    localparam logic [2:0] REG_MASK   = 3'd1;
    localparam logic [2:0] REG_STATUS = 3'd2;
    localparam logic [2:0] REG_OAMADR = 3'd3;
    localparam logic [2:0] REG_OAMDAT = 3'd4;
    localparam logic [2:0] REG_SCROLL = 3'd5;
    localparam logic [2:0] REG_ADDR   = 3'd6;
    localparam logic [2:0] REG_DATA   = 3'd7;

    localparam logic [1:0] MIR_VERTICAL   = 2'd0;
    localparam logic [1:0] MIR_HORIZONTAL = 2'd1;
    localparam logic [1:0] MIR_SINGLE_LO  = 2'd2;
    localparam logic [1:0] MIR_SINGLE_HI  = 2'd3;

    localparam logic [13:0] PAL_BASE  = 14'h3F00;
    localparam logic [13:0] PAT_LAST  = 14'h1FFF;

    // Classified command that travels from front to back.
    typedef struct packed {
        op_t        op;
        logic [2:0] reg_index;
        logic [7:0] wdata;
        logic [2:0] status;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_MEM  = 2'd1,
        ST_OUT  = 2'd2
    } state_t;

endpackage

// ===== hdl/vrvp_front.sv =====
// Front end: accepts input beats and queues them as commands.
// Depends on vrvp_pkg.
module vrvp_front
    import vrvp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,
    output logic        q_valid,
    input  logic        q_pop,
    output cmd_t        q_cmd
);
    cmd_t       mem_reg [QUEUE_DEPTH];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    cmd_t       in_cmd;

    always_comb begin
        in_cmd.op        = op_t'(s_tdata[1:0]);
        in_cmd.reg_index = s_tdata[4:2];
        in_cmd.wdata     = s_tdata[12:5];
        in_cmd.status    = s_tdata[15:13];
    end

    assign s_tready = (cnt_reg != 2'(QUEUE_DEPTH));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = mem_reg[rp_reg];

    always_comb begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = (q_pop && q_valid) ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(q_pop && q_valid);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
        if (push) mem_reg[wp_reg] <= in_cmd;
    end

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 2'(QUEUE_DEPTH)) else $error("queue count overflow");
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'(QUEUE_DEPTH)) |-> !s_tready) else $error("ready while full");
    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd0) |-> !q_valid) else $error("valid while empty");
endmodule

// ===== hdl/vrvp_back.sv =====
// Back end: register file, VRAM/OAM/palette memories and result register.
// Depends on vrvp_pkg.
module vrvp_back
    import vrvp_pkg::*;
#(
    parameter int NAMETABLE_BYTES = NAMETABLE_BYTES_DEF,
    parameter int PATTERN_BYTES   = PATTERN_BYTES_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [1:0] mirror_mode,
    input  logic       q_valid,
    output logic       q_pop,
    input  cmd_t       q_cmd,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata
);
    localparam int NTW = $clog2(NAMETABLE_BYTES);
    localparam int PTW = $clog2(PATTERN_BYTES);

    logic [7:0]  oam_mem [SPRITE_MEM_BYTES];
    logic [7:0]  nt_mem  [NAMETABLE_BYTES];
    logic [7:0]  pat_mem [PATTERN_BYTES];
    logic [7:0]  pal_mem [PALETTE_BYTES];

    // Valid bits: OAM and palette read as zero until written.
    logic [SPRITE_MEM_BYTES-1:0] oam_vld_reg;
    logic [PALETTE_BYTES-1:0]    pal_vld_reg;
    logic [NTW:0]                nt_fill_reg;   // clear sweep counter
    logic [PTW:0]                pat_fill_reg;

    state_t      state_reg, state_next;
    cmd_t        cmd_reg;
    logic [7:0]  ctrl_reg, mask_reg;
    logic [2:0]  stat_reg;
    logic [7:0]  oamp_reg;
    logic        w_reg;
    logic [2:0]  fine_x_reg;
    logic [15:0] t_reg, v_reg;
    logic [7:0]  rbuf_reg;
    logic [7:0]  out_reg, out_next;
    logic        oval_reg;
    logic [7:0]  oam_q_reg, nt_q_reg, pat_q_reg, pal_q_reg;
    logic        oam_qv_reg, pal_qv_reg;

    logic [13:0]      va;
    logic             is_pat, is_pal;
    logic [NTW-1:0]   nt_idx;
    logic [4:0]       pal_idx;
    logic             bank;
    logic             clearing;
    logic [15:0]      v_step;

    assign clearing = !nt_fill_reg[NTW] || !pat_fill_reg[PTW];
    assign va       = v_reg[13:0];
    assign is_pat   = va <= PAT_LAST;
    assign is_pal   = va >= PAL_BASE;
    assign v_step   = v_reg + (ctrl_reg[2] ? 16'd32 : 16'd1);

    always_comb begin
        case (mirror_mode)
            MIR_VERTICAL:   bank = va[10];
            MIR_HORIZONTAL: bank = va[11];
            MIR_SINGLE_LO:  bank = 1'b0;
            default:        bank = 1'b1;
        endcase
        nt_idx  = NTW'({bank, va[9:0]});
        pal_idx = ((va[4:0] & 5'h13) == 5'h10) ? {1'b0, va[3:0]} : va[4:0];
    end

    // Control FSM
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (q_valid && !clearing && !oval_reg) state_next = ST_MEM;
            ST_MEM:  state_next = ST_OUT;
            ST_OUT:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        q_pop = (state_reg == ST_IDLE) && q_valid && !clearing && !oval_reg;
    end

    assign m_tvalid = oval_reg;
    assign m_tdata  = out_reg;

    logic [7:0] mem_val;
    always_comb begin
        if (is_pat)      mem_val = pat_q_reg;
        else if (!is_pal) mem_val = nt_q_reg;
        else mem_val = (pal_qv_reg ? pal_q_reg : 8'd0) & (mask_reg[0] ? 8'h30 : 8'h3F);
    end

    // Result byte: only reads of status, OAM data and VRAM data return data.
    always_comb begin
        out_next = 8'd0;
        if (cmd_reg.op == OP_READ) begin
            case (cmd_reg.reg_index)
                REG_STATUS: out_next = {stat_reg, rbuf_reg[4:0]};
                REG_OAMDAT: out_next = oam_qv_reg ? oam_q_reg : 8'd0;
                REG_DATA:   out_next = is_pal ? mem_val : rbuf_reg;
                default:    out_next = 8'd0;
            endcase
        end
    end

    // Memory ports: read in ST_MEM, write in ST_OUT or by the clear sweep after reset.
    always_ff @(posedge aclk) begin
        oam_q_reg <= oam_mem[oamp_reg];
        nt_q_reg  <= nt_mem[nt_idx];
        pat_q_reg <= pat_mem[va[PTW-1:0]];
        pal_q_reg <= pal_mem[pal_idx];
        if (clearing) begin
            if (!nt_fill_reg[NTW])  nt_mem[nt_fill_reg[NTW-1:0]]   <= 8'd0;
            if (!pat_fill_reg[PTW]) pat_mem[pat_fill_reg[PTW-1:0]] <= 8'd0;
        end else if (state_reg == ST_OUT && cmd_reg.op == OP_WRITE) begin
            if (cmd_reg.reg_index == REG_OAMDAT) oam_mem[oamp_reg] <= cmd_reg.wdata;
            if (cmd_reg.reg_index == REG_DATA) begin
                if (is_pat)       pat_mem[va[PTW-1:0]] <= cmd_reg.wdata;
                else if (!is_pal) nt_mem[nt_idx]       <= cmd_reg.wdata;
                else              pal_mem[pal_idx]     <= cmd_reg.wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && q_pop) cmd_reg <= q_cmd;
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            oam_vld_reg  <= '0;
            pal_vld_reg  <= '0;
            nt_fill_reg  <= '0;
            pat_fill_reg <= '0;
            ctrl_reg <= '0; mask_reg <= '0; stat_reg <= '0; oamp_reg <= '0;
            w_reg <= 1'b0; fine_x_reg <= '0; t_reg <= '0; v_reg <= '0;
            rbuf_reg <= '0; oval_reg <= 1'b0; out_reg <= '0;
            oam_qv_reg <= 1'b0; pal_qv_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (!nt_fill_reg[NTW])  nt_fill_reg  <= nt_fill_reg + 1'b1;
            if (!pat_fill_reg[PTW]) pat_fill_reg <= pat_fill_reg + 1'b1;
            oam_qv_reg <= oam_vld_reg[oamp_reg];
            pal_qv_reg <= pal_vld_reg[pal_idx];
            if (oval_reg && m_tready) oval_reg <= 1'b0;
            if (state_reg == ST_OUT) begin
                oval_reg <= 1'b1;
                out_reg  <= out_next;
                case (cmd_reg.op)
                    OP_WRITE: begin
                        case (cmd_reg.reg_index)
                            REG_CTRL: begin
                                ctrl_reg <= cmd_reg.wdata;
                                t_reg[11:10] <= cmd_reg.wdata[1:0];
                            end
                            REG_MASK:   mask_reg <= cmd_reg.wdata;
                            REG_OAMADR: oamp_reg <= cmd_reg.wdata;
                            REG_OAMDAT: begin
                                oam_vld_reg[oamp_reg] <= 1'b1;
                                oamp_reg <= oamp_reg + 8'd1;
                            end
                            REG_SCROLL: begin
                                if (!w_reg) begin
                                    fine_x_reg <= cmd_reg.wdata[2:0];
                                    t_reg[4:0] <= cmd_reg.wdata[7:3];
                                end else begin
                                    t_reg[14:12] <= cmd_reg.wdata[2:0];
                                    t_reg[9:5]   <= cmd_reg.wdata[7:3];
                                end
                                w_reg <= ~w_reg;
                            end
                            REG_ADDR: begin
                                if (!w_reg) begin
                                    t_reg[15:8] <= {2'b00, cmd_reg.wdata[5:0]};
                                end else begin
                                    t_reg[7:0] <= cmd_reg.wdata;
                                    v_reg      <= {t_reg[15:8], cmd_reg.wdata};
                                end
                                w_reg <= ~w_reg;
                            end
                            REG_DATA: begin
                                if (is_pal) pal_vld_reg[pal_idx] <= 1'b1;
                                v_reg <= v_step;
                            end
                            default: ;
                        endcase
                    end
                    OP_READ: begin
                        case (cmd_reg.reg_index)
                            REG_STATUS: begin
                                stat_reg <= {1'b0, stat_reg[1:0]};
                                w_reg    <= 1'b0;
                            end
                            REG_DATA: begin
                                rbuf_reg <= mem_val;
                                v_reg    <= v_step;
                            end
                            default: ;
                        endcase
                    end
                    OP_STATUS: stat_reg <= cmd_reg.status;
                    default: ;
                endcase
            end
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MEM) |=> (state_reg == ST_OUT)) else $error("fsm skipped");
    a_no_start_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing |-> !q_pop) else $error("pop during clear");
    a_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT) |-> !oval_reg) else $error("result overwritten");
endmodule

// ===== hdl/video_register_vram_port.sv =====
// Top level of the video register VRAM port: APB config, stream ports.
// Depends on vrvp_pkg, vrvp_front, vrvp_back.
// Path: an input beat passes the queue, then the memory read and execute
// states of the back end, before m_tvalid rises with the registered result.
// Flow: the back end runs one command at a time and starts the next only
// after the pending result beat is handed off; the queue takes new beats.
// Reset: synchronous active-low aresetn; after reset a clear sweep zeroes all
// nametable and pattern bytes (PATTERN_BYTES, 8192 default) before items run.
module video_register_vram_port
    import vrvp_pkg::*;
#(
    parameter int NAMETABLE_BYTES = NAMETABLE_BYTES_DEF,
    parameter int PATTERN_BYTES   = PATTERN_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [1:0] operation, [4:2] reg_index, [12:5] write_data, [15:13] status_in
    input  logic [15:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] read_data
    output logic [7:0]  m_tdata
);
    logic [1:0] mirror_reg;
    logic       q_valid, q_pop;
    cmd_t       q_cmd;

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {30'd0, mirror_reg} : 32'd0;

    // Mirroring register at byte address 0.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mirror_reg <= 2'd0;
        end else if (psel && penable && pwrite && paddr == 2'd0) begin
            mirror_reg <= pwdata[1:0];
        end
    end

    vrvp_front u_front (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata,
        .q_valid, .q_pop, .q_cmd
    );

    vrvp_back #(
        .NAMETABLE_BYTES(NAMETABLE_BYTES),
        .PATTERN_BYTES(PATTERN_BYTES)
    ) u_back (
        .aclk, .aresetn, .mirror_mode(mirror_reg),
        .q_valid, .q_pop, .q_cmd,
        .m_tvalid, .m_tready, .m_tdata
    );
endmodule
